// ===== src/spsq_pkg.sv =====
// ---------------------------------------------------------------------------
// spsq_pkg
// Shared types and constants of the servo pulse sequencer.
// ---------------------------------------------------------------------------
package spsq_pkg;

  localparam int NUM_CHANNELS_DEF  = 12;
  localparam int MIN_PULSE_DEF     = 544;
  localparam int MAX_PULSE_DEF     = 2400;
  localparam int DEFAULT_PULSE_DEF = 1500;

  localparam int WIDTH_W    = 12;   // stored pulse width
  localparam int OFF_W      = 8;    // signed 4 us offset
  localparam int LIM_W      = 14;   // signed limit
  localparam int SLOT_W     = 5;    // signed slot index, -1 is the gap
  localparam int ANGLE_W    = 9;
  localparam int DIVIDEND_W = 20;
  localparam int DIVISOR_W  = 13;

  localparam logic [15:0] REFRESH_RESET = 16'd20000;
  localparam int          ANGLE_SPAN    = 180;
  localparam int          ANGLE_LIMIT   = 360;
  localparam int          FRAME_GUARD   = 4;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_ATTACH = 3'd2,
    ACT_DETACH = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LIM,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic CFG_REFRESH  = 1'b0;
  localparam logic CFG_CHANNELS = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/spsq_ram.sv =====
// ---------------------------------------------------------------------------
// spsq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module spsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spsq_div.sv =====
// ---------------------------------------------------------------------------
// spsq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module spsq_div (
  input  logic               clk,
  input  logic               rst_n,
  input  spsq_pkg::div_req_t req,
  output spsq_pkg::div_rsp_t rsp
);

  localparam int DW = spsq_pkg::DIVIDEND_W;
  localparam int SW = spsq_pkg::DIVISOR_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dsr_r;
  logic [DW-1:0] quo_r;
  logic [SW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? SW'(trial - {1'b0, dsr_r}) : trial[SW-1:0];
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== src/servo_pulse_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// servo_pulse_sequencer_top
// Multi-channel servo pulse sequencer with a per-channel table in RAM.
// ---------------------------------------------------------------------------
// Use:
//  - in_* is a stream of command words: tick (one per microsecond), write
//    value, attach, detach and read. Each word yields exactly one out_* word
//    carrying the pulse levels after the command and, for a read, the
//    stored width, its angle and the attached flag.
//  - cfg_* writes the frame period (index 0) and channels_in_use (index 1);
//    write only while no command is in flight.
//  - Per-channel width and limit offsets sit in one RAM (registered read);
//    every command goes read, limit, execute, finish, with the RAM written
//    back in the finish cycle, so accesses never overlap.
//  - out_tvalid rises once a word has passed read, limit, execute and finish;
//    a read whose angle needs a division first waits in the divide state,
//    between execute and finish, for the 20-step divider. Angle writes scale
//    by 1/180 with a reciprocal multiply, no wait. One word is in flight at a
//    time and the next is taken the cycle after the finish.
//  - A result sits in the output register while the receiver stalls; the
//    next word is still accepted and worked up to the finish, which waits
//    for the output register to empty.
//  - Reset (synchronous, rst_n low) marks every RAM entry as unwritten
//    (reads back 1500 us with zero offsets), detaches all channels and
//    restores the configuration defaults. No clearing pass is needed.
// ---------------------------------------------------------------------------
module servo_pulse_sequencer_top #(
  parameter int NUM_CHANNELS  = spsq_pkg::NUM_CHANNELS_DEF,
  parameter int MIN_PULSE     = spsq_pkg::MIN_PULSE_DEF,
  parameter int MAX_PULSE     = spsq_pkg::MAX_PULSE_DEF,
  parameter int DEFAULT_PULSE = spsq_pkg::DEFAULT_PULSE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command word: action[2:0], channel[6:3], value[22:7], min_us[34:23],
  // max_us[46:35], zero pad [47]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // result word: pulse_levels[11:0], width_us[23:12], angle_deg[32:24],
  // is_attached[33], zero pad [39:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int NCH   = NUM_CHANNELS;
  localparam int AW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int WW    = spsq_pkg::WIDTH_W;
  localparam int OW    = spsq_pkg::OFF_W;
  localparam int LW    = spsq_pkg::LIM_W;
  localparam int SW    = spsq_pkg::SLOT_W;
  localparam int DW    = spsq_pkg::DIVIDEND_W;
  localparam int VW    = spsq_pkg::DIVISOR_W;
  localparam int EW    = WW + 2 * OW;          // RAM word: width, min, max
  localparam int ANGLE_W_C = spsq_pkg::ANGLE_W;
  // x/180 = (x/4)/45: (x>>2) * ceil(2^23/45) >> 23, exact for 18-bit x>>2
  localparam int              RP_W        = 36;
  localparam int              ANGLE_SHIFT = 23;
  localparam logic [RP_W-1:0] ANGLE_RECIP = 36'd186414;

  // offset = (nominal - given)/4 toward zero, saturated to int8
  function automatic logic signed [OW-1:0] offset_of(input logic signed [LW-1:0] nominal,
                                                     input logic [WW-1:0] given);
    logic signed [LW:0] d;
    logic signed [LW:0] q;
    d = (LW+1)'(nominal) - $signed({2'b00, given});
    q = (d < 0) ? -((-d) >>> 2) : (d >>> 2);
    if (q < -128)     offset_of = OW'(-128);
    else if (q > 127) offset_of = OW'(127);
    else              offset_of = OW'(q);
  endfunction

  spsq_pkg::state_t state_r, state_nxt;

  // configuration
  logic [15:0] refresh_r;
  logic [3:0]  chans_r;

  // sequencer state
  logic [NCH-1:0]       act_r, act_nxt;
  logic [NCH-1:0]       vld_r, vld_nxt;
  logic [NCH-1:0]       levels_r, levels_nxt;
  logic signed [SW-1:0] slot_r, slot_nxt;
  logic [15:0]          cnt_r, cnt_nxt;
  logic [15:0]          total_r, total_nxt;

  // command word
  spsq_pkg::action_t  it_act_r;
  logic [3:0]         it_ch_r;
  logic signed [15:0] it_val_r;
  logic [WW-1:0]      it_min_r, it_max_r;

  // entry being worked on
  logic                 rd_vld_r;
  logic [WW-1:0]        ent_w_r;
  logic signed [OW-1:0] ent_min_r, ent_max_r;
  logic signed [LW-1:0] lo_r, hi_r;
  logic                 neg_r, zero_r;
  logic [DW-1:0]        scaled_r;

  // output register
  logic        out_valid_r;
  logic [39:0] out_data_r;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // divider
  spsq_pkg::div_req_t div_req;
  spsq_pkg::div_rsp_t div_rsp;

  logic                 in_fire, out_free, ch_ok, ang_mode;
  logic [SW-1:0]        slot_inc;
  logic [4:0]           used;
  logic signed [LW:0]   den, num;
  logic [VW-1:0]        den_mag, num_mag;
  logic [7:0]           v_cl;
  logic [WW-1:0]        levels_out;
  logic [DW-1:0]        q;
  logic [RP_W-1:0]      recip_prod;
  logic [DW-1:0]        wq;
  logic signed [DW+1:0] cand;
  logic signed [DW+1:0] clamped;
  logic [WW-1:0]        w_store;
  logic [ANGLE_W_C-1:0] ang_out;
  logic signed [OW-1:0] new_min, new_max;
  logic                 ex_div, ex_zero, ex_neg;
  logic [DW-1:0]        ex_dividend;
  logic [VW-1:0]        ex_divisor;
  logic [39:0]          out_data_nxt;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == spsq_pkg::S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign ch_ok     = ({1'b0, it_ch_r} < 5'(NCH));
  assign ang_mode  = (it_val_r < 16'(MIN_PULSE));
  assign slot_inc  = SW'(slot_r + 1'b1);
  assign used      = ({1'b0, chans_r} > 5'(NCH)) ? 5'(NCH) : {1'b0, chans_r};

  // ---- configuration port ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= spsq_pkg::REFRESH_RESET;
      chans_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        spsq_pkg::CFG_REFRESH:  refresh_r <= cfg_wdata;
        spsq_pkg::CFG_CHANNELS: chans_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // ---- table RAM ----
  spsq_ram #(
    .WIDTH (EW),
    .DEPTH (NCH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // tick reads the next slot's entry, everything else the addressed channel
  assign ram_raddr = (it_act_r == spsq_pkg::ACT_TICK) ? slot_inc[AW-1:0] : it_ch_r[AW-1:0];

  spsq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spsq_pkg::S_IDLE: if (in_fire) state_nxt = spsq_pkg::S_RD;
      spsq_pkg::S_RD:   state_nxt = spsq_pkg::S_LIM;
      spsq_pkg::S_LIM:  state_nxt = spsq_pkg::S_EXEC;
      spsq_pkg::S_EXEC: state_nxt = ex_div ? spsq_pkg::S_DIV : spsq_pkg::S_FIN;
      spsq_pkg::S_DIV:  if (div_rsp.done) state_nxt = spsq_pkg::S_FIN;
      spsq_pkg::S_FIN:  if (out_free) state_nxt = spsq_pkg::S_IDLE;
      default:          state_nxt = spsq_pkg::S_IDLE;
    endcase
  end

  // ---- execute: decide on a division, form the angle-write product ----
  always_comb begin
    den         = (LW+1)'(hi_r) - (LW+1)'(lo_r);
    num         = $signed({3'b000, ent_w_r}) + 15'sd1 - (LW+1)'(lo_r);
    den_mag     = VW'((den < 0) ? -den : den);
    num_mag     = VW'((num < 0) ? -num : num);
    v_cl        = (it_val_r < 0) ? 8'd0 :
                  (it_val_r > 16'sd180) ? 8'(spsq_pkg::ANGLE_SPAN) : it_val_r[7:0];
    ex_div      = 1'b0;
    ex_zero     = 1'b1;
    ex_neg      = 1'b0;
    ex_dividend = '0;
    ex_divisor  = '0;
    case (it_act_r)
      spsq_pkg::ACT_WRITE: begin
        // angle times the limit span |hi - lo|, scaled by 1/180 in the finish cycle
        if (ch_ok && ang_mode) begin
          ex_neg      = (den < 0);
          ex_dividend = DW'(v_cl * den_mag);
        end
      end
      spsq_pkg::ACT_READ: begin
        if (ch_ok && den != 0 && num != 0 && ((num < 0) == (den < 0))) begin
          ex_div      = 1'b1;
          ex_zero     = 1'b0;
          ex_dividend = DW'(num_mag * 8'(spsq_pkg::ANGLE_SPAN));
          ex_divisor  = den_mag;
        end
      end
      default: ;
    endcase
    div_req.start    = (state_r == spsq_pkg::S_EXEC) && ex_div;
    div_req.dividend = ex_dividend;
    div_req.divisor  = ex_divisor;
  end

  // ---- finish: state update, write-back and result ----
  always_comb begin
    act_nxt    = act_r;
    vld_nxt    = vld_r;
    levels_nxt = levels_r;
    slot_nxt   = slot_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    ram_we     = 1'b0;
    ram_waddr  = it_ch_r[AW-1:0];
    ram_wdata  = {ent_w_r, ent_min_r, ent_max_r};
    q          = div_rsp.quotient;
    recip_prod = RP_W'(scaled_r[DW-1:2]) * ANGLE_RECIP;
    wq         = DW'(recip_prod[RP_W-1:ANGLE_SHIFT]);
    cand       = ang_mode ? ((neg_r ? -$signed({2'b00, wq}) : $signed({2'b00, wq})) + lo_r)
                          : (DW+2)'(it_val_r);
    if (cand < lo_r)      clamped = (DW+2)'(lo_r);
    else if (cand > hi_r) clamped = (DW+2)'(hi_r);
    else                  clamped = cand;
    if (clamped < 0)                  w_store = '0;
    else if (clamped > (DW+2)'(4095)) w_store = '1;
    else                              w_store = clamped[WW-1:0];
    new_min    = offset_of(LW'(MIN_PULSE), it_min_r);
    new_max    = offset_of(LW'(MAX_PULSE), it_max_r);
    ang_out    = zero_r ? '0 :
                 (q > DW'(spsq_pkg::ANGLE_LIMIT)) ? ANGLE_W_C'(spsq_pkg::ANGLE_LIMIT)
                                                   : q[ANGLE_W_C-1:0];
    if (state_r == spsq_pkg::S_FIN && out_free) begin
      case (it_act_r)
        spsq_pkg::ACT_TICK: begin
          if (act_r != '0) begin
            if (cnt_r <= 16'd1) begin
              if (slot_r < 0) begin
                total_nxt = '0;
              end else if ({1'b0, slot_r[SW-2:0]} < {1'b0, chans_r} &&
                           act_r[slot_r[AW-1:0]]) begin
                levels_nxt[slot_r[AW-1:0]] = 1'b0;
              end
              if (slot_inc < used) begin
                slot_nxt  = slot_inc;
                cnt_nxt   = 16'(ent_w_r);
                total_nxt = total_nxt + 16'(ent_w_r);
                if (act_r[slot_inc[AW-1:0]]) levels_nxt[slot_inc[AW-1:0]] = 1'b1;
              end else begin
                if (17'(total_nxt) + 17'(spsq_pkg::FRAME_GUARD) < 17'(refresh_r)) begin
                  cnt_nxt = refresh_r - total_nxt;
                end else begin
                  cnt_nxt = 16'd1;
                end
                slot_nxt = '1;
              end
            end else begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
        spsq_pkg::ACT_WRITE: begin
          if (ch_ok) begin
            ram_we    = 1'b1;
            ram_wdata = {w_store, ent_min_r, ent_max_r};
            vld_nxt[it_ch_r[AW-1:0]] = 1'b1;
          end
        end
        spsq_pkg::ACT_ATTACH: begin
          if (ch_ok) begin
            ram_we    = 1'b1;
            ram_wdata = {WW'(DEFAULT_PULSE), new_min, new_max};
            vld_nxt[it_ch_r[AW-1:0]] = 1'b1;
            if (act_r == '0) cnt_nxt = refresh_r;
            act_nxt[it_ch_r[AW-1:0]] = 1'b1;
          end
        end
        spsq_pkg::ACT_DETACH: begin
          if (ch_ok) act_nxt[it_ch_r[AW-1:0]] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < WW; i++) begin : g_lv
    if (i < NCH) begin : g_on
      assign levels_out[i] = levels_nxt[i];
    end else begin : g_off
      assign levels_out[i] = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = {6'b0, 1'b0, 9'b0, 12'b0, levels_out};
    if (it_act_r == spsq_pkg::ACT_READ && ch_ok) begin
      out_data_nxt = {6'b0, act_r[it_ch_r[AW-1:0]], ang_out, ent_w_r, levels_out};
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spsq_pkg::S_IDLE;
      act_r       <= '0;
      vld_r       <= '0;
      levels_r    <= '0;
      slot_r      <= '1;
      cnt_r       <= spsq_pkg::REFRESH_RESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      act_r    <= act_nxt;
      vld_r    <= vld_nxt;
      levels_r <= levels_nxt;
      slot_r   <= slot_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      if (state_r == spsq_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_act_r <= spsq_pkg::action_t'(in_tdata[2:0]);
      it_ch_r  <= in_tdata[6:3];
      it_val_r <= $signed(in_tdata[22:7]);
      it_min_r <= in_tdata[34:23];
      it_max_r <= in_tdata[46:35];
    end
    if (state_r == spsq_pkg::S_RD) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
    if (state_r == spsq_pkg::S_LIM) begin
      // unwritten entries read as default width with zero offsets
      ent_w_r   <= rd_vld_r ? ram_rdata[EW-1 -: WW] : WW'(DEFAULT_PULSE);
      ent_min_r <= rd_vld_r ? $signed(ram_rdata[2*OW-1 -: OW]) : '0;
      ent_max_r <= rd_vld_r ? $signed(ram_rdata[OW-1:0]) : '0;
      lo_r <= LW'(MIN_PULSE) - (LW'(rd_vld_r ? $signed(ram_rdata[2*OW-1 -: OW]) : 8'sd0) <<< 2);
      hi_r <= LW'(MAX_PULSE) - (LW'(rd_vld_r ? $signed(ram_rdata[OW-1:0]) : 8'sd0) <<< 2);
    end
    if (state_r == spsq_pkg::S_EXEC) begin
      neg_r    <= ex_neg;
      zero_r   <= ex_zero;
      scaled_r <= ex_dividend;
    end
    if (state_r == spsq_pkg::S_FIN && out_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- assertions ----
  a_ram_we_fin : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == spsq_pkg::S_FIN))
    else $error("table written outside finish");

  a_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r == '1) || (5'(slot_r) < 5'(NCH)))
    else $error("slot index out of range");

  a_div_wait : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spsq_pkg::S_DIV && !div_rsp.done) |=> (state_r == spsq_pkg::S_DIV))
    else $error("left divide wait early");

  a_fin_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spsq_pkg::S_FIN && !out_free) |=> (state_r == spsq_pkg::S_FIN))
    else $error("finish overran a waiting result");

endmodule

// ===== test/servo_pulse_sequencer_top_tb.sv =====
// ---------------------------------------------------------------------------
// servo_pulse_sequencer_top_tb
// Stream-level test of the servo pulse sequencer: directed and random
// command words, checked word by word against a behavioural predictor.
// ---------------------------------------------------------------------------
module servo_pulse_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NCH        = spsq_pkg::NUM_CHANNELS_DEF;
  localparam logic [2:0]  ACT_SPARE  = 3'd5;   // first unused action code
  localparam logic [2:0]  ACT_LAST   = 3'd7;
  localparam int          IDLE_LIMIT = 5000;   // cycles without any handshake
  localparam int          DRAIN_WAIT = 40;     // beyond the longest latency
  localparam int          HOLD_LEN   = 300;    // long receiver hold-off

  typedef struct {
    logic [2:0]         act;
    logic [3:0]         ch;
    logic signed [15:0] val;
    logic [11:0]        mn;
    logic [11:0]        mx;
  } cmd_t;

  typedef struct {
    logic [11:0] lv;
    logic [11:0] w;
    logic [8:0]  ang;
    logic        att;
  } servo_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = spsq_pkg::CFG_REFRESH;
  logic [15:0] cfg_wdata = '0;

  servo_pulse_sequencer_top dut (.*);

  always #4 clk = ~clk;

  // predictor state
  int          p_refresh, p_chans;
  int          p_width [NCH];
  int          p_minoff [NCH];
  int          p_maxoff [NCH];
  logic [11:0] p_active, p_levels;
  int          p_slot, p_count, p_total;

  servo_word_t pending_words[$];
  int          mismatches = 0;
  int          words_sent = 0, words_seen = 0, reads_sent = 0, pulse_edges = 0;
  bit          quiet = 0;        // no idling on either side
  bit          hold_req = 0;     // ask the receiver for a long hold-off
  int          idle_cycles = 0;

  function automatic int sat(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int low_lim(int ch);
    return spsq_pkg::MIN_PULSE_DEF - 4 * p_minoff[ch];
  endfunction

  function automatic int high_lim(int ch);
    return spsq_pkg::MAX_PULSE_DEF - 4 * p_maxoff[ch];
  endfunction

  function automatic void pred_reset();
    p_refresh = spsq_pkg::REFRESH_RESET;
    p_chans   = 0;
    for (int i = 0; i < NCH; i++) begin
      p_width[i]  = spsq_pkg::DEFAULT_PULSE_DEF;
      p_minoff[i] = 0;
      p_maxoff[i] = 0;
    end
    p_active = '0;
    p_levels = '0;
    p_slot   = -1;
    p_count  = p_refresh;
    p_total  = 0;
  endfunction

  // end of the running slot: drop its level, raise the next or wait the gap
  function automatic void advance_slot();
    int used;
    int ch;
    used = (p_chans > NCH) ? NCH : p_chans;
    ch   = p_slot;
    if (ch < 0) p_total = 0;
    else if (ch < p_chans && p_active[ch]) p_levels[ch] = 1'b0;
    ch++;
    if (ch < used) begin
      p_slot  = ch;
      p_count = p_width[ch];
      p_total = (p_total + p_width[ch]) & 16'hFFFF;
      if (p_active[ch]) p_levels[ch] = 1'b1;
    end else begin
      p_count = (p_total + spsq_pkg::FRAME_GUARD < p_refresh) ? p_refresh - p_total : 1;
      p_slot  = -1;
    end
  endfunction

  function automatic servo_word_t predict_servo(cmd_t c);
    servo_word_t r;
    int ch, v, lo, hi, a;
    bit ok;
    ch = c.ch;
    v  = c.val;
    ok = ch < NCH;
    r  = '{lv: 0, w: 0, ang: 0, att: 0};
    case (c.act)
      spsq_pkg::ACT_TICK: begin
        if (p_active != 0) begin
          if (p_count <= 1) advance_slot();
          else p_count--;
        end
      end
      spsq_pkg::ACT_WRITE: if (ok) begin
        lo = low_lim(ch);
        hi = high_lim(ch);
        if (v < spsq_pkg::MIN_PULSE_DEF)
          v = sat(v, 0, spsq_pkg::ANGLE_SPAN) * (hi - lo) / spsq_pkg::ANGLE_SPAN + lo;
        if (v < lo) v = lo;
        else if (v > hi) v = hi;
        p_width[ch] = sat(v, 0, 4095);
      end
      spsq_pkg::ACT_ATTACH: if (ok) begin
        p_width[ch]  = spsq_pkg::DEFAULT_PULSE_DEF;
        p_minoff[ch] = sat((spsq_pkg::MIN_PULSE_DEF - int'(c.mn)) / 4, -128, 127);
        p_maxoff[ch] = sat((spsq_pkg::MAX_PULSE_DEF - int'(c.mx)) / 4, -128, 127);
        if (p_active == 0) p_count = p_refresh;
        p_active[ch] = 1'b1;
      end
      spsq_pkg::ACT_DETACH: if (ok) p_active[ch] = 1'b0;
      spsq_pkg::ACT_READ: if (ok) begin
        lo = low_lim(ch);
        hi = high_lim(ch);
        a  = (hi != lo) ? (p_width[ch] + 1 - lo) * spsq_pkg::ANGLE_SPAN / (hi - lo) : 0;
        r.w   = 12'(p_width[ch]);
        r.ang = 9'(sat(a, 0, spsq_pkg::ANGLE_LIMIT));
        r.att = p_active[ch];
      end
      default: ;
    endcase
    r.lv = p_levels;
    return r;
  endfunction

  // one command word onto the input stream, optionally after an idle burst
  task automatic send_cmd(cmd_t c);
    servo_word_t e;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, c.mx, c.mn, c.val, c.ch, c.act};
    do @(posedge clk); while (!in_tready);
    e = predict_servo(c);
    pending_words.push_back(e);
    words_sent++;
    if (c.act == spsq_pkg::ACT_READ) reads_sent++;
  endtask

  task automatic send(logic [2:0] act, int ch = 0, int val = 0, int mn = 0, int mx = 0);
    cmd_t c;
    c = '{act: act, ch: 4'(ch), val: 16'(val), mn: 12'(mn), mx: 12'(mx)};
    send_cmd(c);
  endtask

  task automatic ticks(int n);
    repeat (n) send(spsq_pkg::ACT_TICK, $urandom_range(0, 15), $urandom, $urandom, $urandom);
  endtask

  // registers change only with nothing in flight
  task automatic set_config(int refresh, int chans);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= spsq_pkg::CFG_REFRESH;
    cfg_wdata <= 16'(refresh);
    @(negedge clk);
    cfg_index <= spsq_pkg::CFG_CHANNELS;
    cfg_wdata <= 16'(chans);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    p_refresh = refresh & 16'hFFFF;
    p_chans   = chans & 4'hF;
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int k;
    c.ch  = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(NCH, 15)
                                           : $urandom_range(0, NCH - 1));
    c.val = 16'($urandom);
    c.mn  = 12'($urandom);
    c.mx  = 12'($urandom);
    k = $urandom_range(0, 99);
    if (k < 58) c.act = spsq_pkg::ACT_TICK;
    else if (k < 72) begin
      c.act = spsq_pkg::ACT_WRITE;
      case ($urandom_range(0, 3))
        0: c.val = 16'($urandom_range(0, 200) - 10);  // angles, some out of range
        1: c.val = 16'($urandom_range(0, 120));       // small angles, all in range
        2: c.val = 16'($urandom_range(500, 2600));
        default: ;                                    // any 16-bit value
      endcase
    end else if (k < 81) begin
      c.act = spsq_pkg::ACT_ATTACH;
      if ($urandom_range(0, 1)) begin
        c.mn = 12'($urandom_range(0, 700));
        c.mx = 12'($urandom_range(1800, 2600));
      end
    end else if (k < 86) c.act = spsq_pkg::ACT_DETACH;
    else if (k < 96) c.act = spsq_pkg::ACT_READ;
    else c.act = 3'($urandom_range(ACT_SPARE, ACT_LAST));
    return c;
  endfunction

  task automatic random_words(int n);
    repeat (n) send_cmd(random_cmd());
  endtask

  // ---- receiver: random back-pressure, one long hold-off on request ----
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---- result checker ----
  always @(posedge clk) begin
    servo_word_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      a = '{lv: out_tdata[11:0], w: out_tdata[23:12], ang: out_tdata[32:24],
            att: out_tdata[33]};
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        e = pending_words.pop_front();
        if (e.lv != a.lv || e.w != a.w || e.ang != a.ang || e.att != a.att) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: exp lv=%h w=%0d ang=%0d att=%b, got lv=%h w=%0d ang=%0d att=%b",
                     words_seen, e.lv, e.w, e.ang, e.att, a.lv, a.w, a.ang, a.att);
        end
      end
    end
  end

  always @(posedge clk) if (out_tvalid && out_tready && out_tdata[11:0] != 0) pulse_edges++;

  // ---- watchdog: stalls with no handshake on either side ----
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---- tests ----
  task automatic test_reset_state();
    // defaults: 1500 us everywhere, nothing attached, ticks inert
    send(spsq_pkg::ACT_READ, 0);
    send(spsq_pkg::ACT_READ, NCH - 1);
    ticks(4);
  endtask

  task automatic test_directed();
    set_config(60, 3);
    send(spsq_pkg::ACT_ATTACH, 0, 0, 544, 2400);
    send(spsq_pkg::ACT_ATTACH, 1, 0, 4095, 0);          // both offsets saturate
    send(spsq_pkg::ACT_ATTACH, 2, 0, 0, 4095);
    send(spsq_pkg::ACT_WRITE, 0, -32768);               // negative angle clamps to 0
    send(spsq_pkg::ACT_WRITE, 0, 32767);                // clamps to the high limit
    send(spsq_pkg::ACT_WRITE, 1, 180);
    send(spsq_pkg::ACT_WRITE, 1, 543);                  // largest angle-coded value
    send(spsq_pkg::ACT_WRITE, 2, 544);
    send(spsq_pkg::ACT_WRITE, 2, 0);
    send(spsq_pkg::ACT_READ, 0);
    send(spsq_pkg::ACT_READ, 1);                        // saturated limits, high still above low
    send(spsq_pkg::ACT_READ, 2);
    send(spsq_pkg::ACT_ATTACH, 3, 0, 2400, 544);        // both offsets saturate, limits as on channel 1
    send(spsq_pkg::ACT_READ, 3);
    send(spsq_pkg::ACT_WRITE, NCH, 100);                // out-of-range channel ignored
    send(spsq_pkg::ACT_ATTACH, 15, 0, 0, 0);
    send(spsq_pkg::ACT_READ, 15);
    send(ACT_SPARE, 0);
    send(ACT_LAST, 5);
    send(spsq_pkg::ACT_DETACH, 4);
    send(spsq_pkg::ACT_WRITE, 4, 90);                   // stored while detached
    send(spsq_pkg::ACT_READ, 4);
    ticks(70);                                          // frame gap runs out, channel 0 pulse starts
    send(spsq_pkg::ACT_DETACH, 0);                      // mid-pulse detach
    ticks(60);
  endtask

  task automatic test_random_settings();
    int refr [6] = '{40, 0, 200, 65535, 20000, 100};
    int chn  [6] = '{12, 15, 4, 1, 0, 12};
    for (int i = 0; i < 6; i++) begin
      set_config(refr[i], chn[i]);
      random_words(95);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    random_words(30);
  endtask

  task automatic test_no_idle();
    set_config(80, 12);
    quiet = 1;
    random_words(90);
  endtask

  initial begin
    pred_reset();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed();
    test_random_settings();
    test_backpressure();
    test_no_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d command words (%0d reads), %0d result words, eight register settings",
             words_sent, reads_sent, words_seen);
    $display("results with a pulse high: %0d, mismatches: %0d", pulse_edges, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
